// ===== src/assert_macros.svh =====
// assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr holds at every clock edge outside reset
`define SRA_ASSERT_HOLDS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: invariant");

// cond implies expr in the same cycle
`define SRA_ASSERT_IMPL(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed: implication");

// cond implies expr in the next cycle
`define SRA_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed: next cycle");

`endif

// ===== src/sra_pkg.sv =====
package sra_pkg;

   localparam int DATA_W = 16;
   localparam int STAT_W = 3;

   localparam logic [STAT_W-1:0] STAT_NORMAL  = 3'd0;
   localparam logic [STAT_W-1:0] STAT_HOT     = 3'd1;
   localparam logic [STAT_W-1:0] STAT_COLD    = 3'd2;
   localparam logic [STAT_W-1:0] STAT_UNKNOWN = 3'd3;
   localparam logic [STAT_W-1:0] STAT_STORED  = 3'd4;
   localparam logic [STAT_W-1:0] STAT_FULL    = 3'd5;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam logic REG_MAX_TEMP = 1'b0;
   localparam logic REG_MIN_TEMP = 1'b1;

   localparam logic signed [DATA_W-1:0] MAX_TEMP_RESET = 16'sd2500;
   localparam logic signed [DATA_W-1:0] MIN_TEMP_RESET = 16'sd1000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_UPDATE,
      ST_SUM,
      ST_CMP,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

// ===== src/sensor_running_average_alert.sv =====
// channel  direction  handshake              payload
// req      in         req_valid / req_ready  operation, sensor, room_id, sample_value
// rsp      out        rsp_valid / rsp_ready  status, room_out, average
// csr      in         psel / penable         max_temp (0x0), min_temp (0x4), read back
//
// One word at a time. A load, or a sample on an empty table, passes from the result
// registers to the output register once it is free. A sample walks the entry memory one
// entry per cycle (up to TABLE_ENTRIES), then sums the samples held from the ring memory,
// runs the bit-serial divider and hands the result to the output register.
// Reset clears state, entry count, rsp_valid and thresholds; the memories are not cleared.
// req_ready is low until the result enters the output register, which waits on rsp_ready.
module sensor_running_average_alert #(
   parameter int TABLE_ENTRIES  = 64,
   parameter int HISTORY_LENGTH = 5
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_operation,
   input  logic        [sra_pkg::DATA_W-1:0]  req_sensor,
   input  logic        [sra_pkg::DATA_W-1:0]  req_room_id,
   input  logic signed [sra_pkg::DATA_W-1:0]  req_sample_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic        [sra_pkg::STAT_W-1:0]  rsp_status,
   output logic        [sra_pkg::DATA_W-1:0]  rsp_room_out,
   output logic signed [sra_pkg::DATA_W-1:0]  rsp_average,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic        [2:0]                  paddr,
   input  logic        [31:0]                 pwdata,
   output logic        [31:0]                 prdata,
   output logic                               pready
);

`include "assert_macros.svh"

   localparam int DW      = sra_pkg::DATA_W;
   localparam int SW      = sra_pkg::STAT_W;
   localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNTE_W  = $clog2(TABLE_ENTRIES + 1);
   localparam int POS_W   = (HISTORY_LENGTH > 1) ? $clog2(HISTORY_LENGTH) : 1;
   localparam int CNT_W   = $clog2(HISTORY_LENGTH + 1);
   localparam int SUM_W   = 17 + $clog2(HISTORY_LENGTH);
   localparam int MUL_W   = 17 + CNT_W;
   localparam int RING_D  = TABLE_ENTRIES * HISTORY_LENGTH;
   localparam int RA_W    = (RING_D > 1) ? $clog2(RING_D) : 1;
   localparam int ENT_W   = 2 * DW + POS_W + CNT_W;

   sra_pkg::state_type state_ff, state_in;

   logic [DW-1:0]           sid_ff, sid_in;
   logic [DW-1:0]           smp_ff, smp_in;
   logic [CNTE_W-1:0]       count_ff, count_in;
   logic [IDX_W-1:0]        chk_ff, chk_in;
   logic [IDX_W-1:0]        hit_ff, hit_in;
   logic [RA_W-1:0]         base_ff, base_in;
   logic [DW-1:0]           room_ff, room_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [CNT_W-1:0]        held_ff, held_in;
   logic [CNT_W-1:0]        rk_ff, rk_in;
   logic                    pend_ff, pend_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [SW-1:0]           res_stat_ff, res_stat_in;
   logic [DW-1:0]           res_room_ff, res_room_in;
   logic [DW-1:0]           res_avg_ff, res_avg_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]           rsp_stat_ff, rsp_stat_in;
   logic [DW-1:0]           rsp_room_ff, rsp_room_in;
   logic [DW-1:0]           rsp_avg_ff, rsp_avg_in;
   logic signed [DW-1:0]    max_temp_ff, max_temp_in;
   logic signed [DW-1:0]    min_temp_ff, min_temp_in;

   logic                    ent_wr_en;
   logic [IDX_W-1:0]        ent_wr_addr;
   logic [ENT_W-1:0]        ent_wr_data;
   logic [IDX_W-1:0]        ent_rd_addr;
   logic [ENT_W-1:0]        ent_rd_data;
   logic                    ring_wr_en;
   logic [RA_W-1:0]         ring_wr_addr;
   logic [RA_W-1:0]         ring_rd_addr;
   logic [DW-1:0]           ring_rd_data;

   logic                    div_start;
   logic                    div_done;
   logic signed [DW-1:0]    div_quo;

   logic [DW-1:0]           ent_sensor;
   logic [DW-1:0]           ent_room;
   logic [POS_W-1:0]        ent_pos;
   logic [CNT_W-1:0]        ent_held;
   logic [POS_W-1:0]        pos_next;
   logic [CNT_W-1:0]        held_next;
   logic                    issue;
   logic signed [MUL_W-1:0] hi_lim;
   logic signed [MUL_W-1:0] lo_lim;
   logic signed [MUL_W-1:0] sum_ext;
   logic                    req_fire;
   logic                    csr_wr;

   assign ent_sensor = ent_rd_data[ENT_W-1 -: DW];
   assign ent_room   = ent_rd_data[ENT_W-DW-1 -: DW];
   assign ent_pos    = ent_rd_data[CNT_W+POS_W-1 -: POS_W];
   assign ent_held   = ent_rd_data[CNT_W-1:0];

   assign pos_next  = (pos_ff == POS_W'(HISTORY_LENGTH - 1)) ? '0 : pos_ff + POS_W'(1);
   assign held_next = (held_ff < CNT_W'(HISTORY_LENGTH)) ? held_ff + CNT_W'(1) : held_ff;
   assign issue     = (rk_ff < held_ff);

   assign sum_ext = MUL_W'(sum_ff);
   assign hi_lim  = MUL_W'(max_temp_ff) * MUL_W'($signed({1'b0, held_ff}));
   assign lo_lim  = MUL_W'(min_temp_ff) * MUL_W'($signed({1'b0, held_ff}));

   assign req_ready = (state_ff == sra_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_wr    = psel && penable && pwrite;

   assign ent_rd_addr  = (state_ff == sra_pkg::ST_SEARCH) ? chk_ff + IDX_W'(1) : '0;
   assign ring_wr_addr = base_ff + RA_W'(pos_ff);
   assign ring_rd_addr = base_ff + RA_W'(rk_ff);

   always_comb begin
      state_in     = state_ff;
      sid_in       = sid_ff;
      smp_in       = smp_ff;
      count_in     = count_ff;
      chk_in       = chk_ff;
      hit_in       = hit_ff;
      base_in      = base_ff;
      room_in      = room_ff;
      pos_in       = pos_ff;
      held_in      = held_ff;
      rk_in        = rk_ff;
      pend_in      = 1'b0;
      sum_in       = sum_ff;
      res_stat_in  = res_stat_ff;
      res_room_in  = res_room_ff;
      res_avg_in   = res_avg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_stat_in  = rsp_stat_ff;
      rsp_room_in  = rsp_room_ff;
      rsp_avg_in   = rsp_avg_ff;
      max_temp_in  = max_temp_ff;
      min_temp_in  = min_temp_ff;
      ent_wr_en    = 1'b0;
      ent_wr_addr  = hit_ff;
      ent_wr_data  = {sid_ff, room_ff, pos_next, held_next};
      ring_wr_en   = 1'b0;
      div_start    = 1'b0;

      if (csr_wr) begin
         case (paddr[2])
            sra_pkg::REG_MAX_TEMP: max_temp_in = pwdata[DW-1:0];
            sra_pkg::REG_MIN_TEMP: min_temp_in = pwdata[DW-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         sra_pkg::ST_IDLE: begin
            if (req_fire) begin
               sid_in = req_sensor;
               smp_in = req_sample_value;
               chk_in = '0;
               res_room_in = '0;
               res_avg_in  = '0;
               if (req_operation == sra_pkg::OP_LOAD) begin
                  state_in = sra_pkg::ST_DONE;
                  if (count_ff == CNTE_W'(TABLE_ENTRIES)) begin
                     res_stat_in = sra_pkg::STAT_FULL;
                  end else begin
                     ent_wr_en   = 1'b1;
                     ent_wr_addr = count_ff[IDX_W-1:0];
                     ent_wr_data = {req_sensor, req_room_id, POS_W'(0), CNT_W'(0)};
                     count_in    = count_ff + CNTE_W'(1);
                     res_stat_in = sra_pkg::STAT_STORED;
                     res_room_in = req_room_id;
                  end
               end else if (count_ff == '0) begin
                  res_stat_in = sra_pkg::STAT_UNKNOWN;
                  state_in    = sra_pkg::ST_DONE;
               end else begin
                  state_in = sra_pkg::ST_SEARCH;
               end
            end
         end
         sra_pkg::ST_SEARCH: begin
            if (ent_sensor == sid_ff) begin
               hit_in   = chk_ff;
               base_in  = RA_W'(chk_ff * HISTORY_LENGTH);
               room_in  = ent_room;
               pos_in   = ent_pos;
               held_in  = ent_held;
               state_in = sra_pkg::ST_UPDATE;
            end else if ((CNTE_W'(chk_ff) + CNTE_W'(1)) == count_ff) begin
               res_stat_in = sra_pkg::STAT_UNKNOWN;
               state_in    = sra_pkg::ST_DONE;
            end else begin
               chk_in = chk_ff + IDX_W'(1);
            end
         end
         sra_pkg::ST_UPDATE: begin
            ring_wr_en = 1'b1;
            ent_wr_en  = 1'b1;
            held_in    = held_next;
            rk_in      = '0;
            sum_in     = '0;
            state_in   = sra_pkg::ST_SUM;
         end
         sra_pkg::ST_SUM: begin
            pend_in = issue;
            if (issue) begin
               rk_in = rk_ff + CNT_W'(1);
            end
            if (pend_ff) begin
               sum_in = sum_ff + SUM_W'($signed(ring_rd_data));
            end
            if (!issue && !pend_ff) begin
               state_in = sra_pkg::ST_CMP;
            end
         end
         sra_pkg::ST_CMP: begin
            div_start   = 1'b1;
            res_room_in = room_ff;
            if (sum_ext > hi_lim) begin
               res_stat_in = sra_pkg::STAT_HOT;
            end else if (sum_ext < lo_lim) begin
               res_stat_in = sra_pkg::STAT_COLD;
            end else begin
               res_stat_in = sra_pkg::STAT_NORMAL;
            end
            state_in = sra_pkg::ST_DIV;
         end
         sra_pkg::ST_DIV: begin
            if (div_done) begin
               res_avg_in = div_quo;
               state_in   = sra_pkg::ST_DONE;
            end
         end
         sra_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_stat_in  = res_stat_ff;
               rsp_room_in  = res_room_ff;
               rsp_avg_in   = res_avg_ff;
               state_in     = sra_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sra_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sra_pkg::ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_temp_ff  <= sra_pkg::MAX_TEMP_RESET;
         min_temp_ff  <= sra_pkg::MIN_TEMP_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         max_temp_ff  <= max_temp_in;
         min_temp_ff  <= min_temp_in;
      end
      sid_ff      <= sid_in;
      smp_ff      <= smp_in;
      chk_ff      <= chk_in;
      hit_ff      <= hit_in;
      base_ff     <= base_in;
      room_ff     <= room_in;
      pos_ff      <= pos_in;
      held_ff     <= held_in;
      rk_ff       <= rk_in;
      sum_ff      <= sum_in;
      res_stat_ff <= res_stat_in;
      res_room_ff <= res_room_in;
      res_avg_ff  <= res_avg_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_room_ff <= rsp_room_in;
      rsp_avg_ff  <= rsp_avg_in;
   end

   sra_ram #(
      .WIDTH (ENT_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (ent_wr_addr),
      .wr_data (ent_wr_data),
      .rd_addr (ent_rd_addr),
      .rd_data (ent_rd_data)
   );

   sra_ram #(
      .WIDTH (DW),
      .DEPTH (RING_D)
   ) u_ring_ram (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (ring_wr_addr),
      .wr_data (smp_ff),
      .rd_addr (ring_rd_addr),
      .rd_data (ring_rd_data)
   );

   sra_div #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (held_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign prdata = (paddr[2] == sra_pkg::REG_MIN_TEMP) ? 32'(min_temp_ff) : 32'(max_temp_ff);
   assign pready = 1'b1;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_stat_ff;
   assign rsp_room_out = rsp_room_ff;
   assign rsp_average  = rsp_avg_ff;

   `SRA_ASSERT_HOLDS(a_count_bound, clock, reset, count_ff <= CNTE_W'(TABLE_ENTRIES))
   `SRA_ASSERT_IMPL(a_div_done_in_div, clock, reset, div_done, state_ff == sra_pkg::ST_DIV)
   `SRA_ASSERT_IMPL(a_read_bound, clock, reset, state_ff == sra_pkg::ST_SUM, rk_ff <= held_ff)
   `SRA_ASSERT_NEXT(a_cmp_to_div, clock, reset, state_ff == sra_pkg::ST_CMP, state_ff == sra_pkg::ST_DIV)

endmodule

// ===== src/sra_ram.sv =====
module sra_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/sra_div.sv =====
module sra_div #(
   parameter int SUM_W = 20,
   parameter int CNT_W = 3
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic signed [SUM_W-1:0]         dividend,
   input  logic        [CNT_W-1:0]         divisor,
   output logic                            done,
   output logic signed [sra_pkg::DATA_W-1:0] quotient
);

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              neg_ff, neg_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  dvs_ff, dvs_in;
   logic [CNT_W:0]    trial;
   logic [SUM_W-1:0]  signed_quo;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      neg_in  = neg_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, quo_ff[SUM_W-1]};
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(SUM_W);
         neg_in  = dividend[SUM_W-1];
         quo_in  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = CNT_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = CNT_W'(trial);
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      neg_ff  <= neg_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign signed_quo = neg_ff ? (~quo_ff + SUM_W'(1)) : quo_ff;
   assign quotient   = signed_quo[sra_pkg::DATA_W-1:0];
   assign done       = done_ff;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   localparam int DW            = sra_pkg::DATA_W;
   localparam int SW            = sra_pkg::STAT_W;
   localparam int TABLE_SIZE    = 64;
   localparam int RING_LEN      = 5;
   localparam int MAX_WAIT      = 18;
   localparam int SETTLE_CYCLES = 120;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int PHASE_WORDS   = 130;
   localparam int PHASE_COUNT   = 5;
   localparam int LONG_HOLD     = 600;
   localparam int MAX_PRINTS    = 100;

   typedef struct packed {
      logic [SW-1:0]        status;
      logic [DW-1:0]        room;
      logic signed [DW-1:0] average;
   } alert_word_type;

   class alarm_scoreboard;
      logic [DW-1:0]        tbl_sensor [TABLE_SIZE];
      logic [DW-1:0]        tbl_room [TABLE_SIZE];
      logic signed [DW-1:0] readings [TABLE_SIZE][RING_LEN];
      int                   next_slot [TABLE_SIZE];
      int                   held [TABLE_SIZE];
      int                   entries;
      logic signed [DW-1:0] hot_limit;
      logic signed [DW-1:0] cold_limit;
      alert_word_type       alerts_due [$];
      int                   errors;
      int                   words_seen;

      function new();
         entries    = 0;
         hot_limit  = sra_pkg::MAX_TEMP_RESET;
         cold_limit = sra_pkg::MIN_TEMP_RESET;
         errors     = 0;
         words_seen = 0;
         foreach (readings[i, j]) readings[i][j] = '0;
         foreach (next_slot[i]) begin
            next_slot[i] = 0;
            held[i]      = 0;
         end
      endfunction

      function void set_threshold(logic idx, logic signed [DW-1:0] value);
         if (idx == sra_pkg::REG_MAX_TEMP) begin
            hot_limit = value;
         end else begin
            cold_limit = value;
         end
      endfunction

      function int pending();
         return alerts_due.size();
      endfunction

      function void note_input(logic op, logic [DW-1:0] sid, logic [DW-1:0] rid,
                               logic signed [DW-1:0] value);
         alert_word_type w;
         int             hit;
         int             n;
         int             sum;
         w = '0;
         if (op == sra_pkg::OP_LOAD) begin
            if (entries >= TABLE_SIZE) begin
               w.status = sra_pkg::STAT_FULL;
            end else begin
               tbl_sensor[entries] = sid;
               tbl_room[entries]   = rid;
               for (int j = 0; j < RING_LEN; j++) readings[entries][j] = '0;
               next_slot[entries] = 0;
               held[entries]      = 0;
               entries++;
               w.status = sra_pkg::STAT_STORED;
               w.room   = rid;
            end
         end else begin
            hit = -1;
            for (int i = 0; i < entries; i++) begin
               if (tbl_sensor[i] == sid) begin
                  hit = i;
                  break;
               end
            end
            if (hit < 0) begin
               w.status = sra_pkg::STAT_UNKNOWN;
            end else begin
               readings[hit][next_slot[hit]] = value;
               next_slot[hit] = (next_slot[hit] + 1) % RING_LEN;
               if (held[hit] < RING_LEN) held[hit]++;
               n   = held[hit];
               sum = 0;
               for (int j = 0; j < n; j++) sum += readings[hit][j];
               w.room    = tbl_room[hit];
               w.average = DW'(sum / n);
               if (sum > hot_limit * n) begin
                  w.status = sra_pkg::STAT_HOT;
               end else if (sum < cold_limit * n) begin
                  w.status = sra_pkg::STAT_COLD;
               end else begin
                  w.status = sra_pkg::STAT_NORMAL;
               end
            end
         end
         alerts_due.push_back(w);
      endfunction

      task report(string msg);
         if (errors < MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_result(logic [SW-1:0] st, logic [DW-1:0] room,
                        logic signed [DW-1:0] avg);
         alert_word_type w;
         words_seen++;
         if (alerts_due.size() == 0) begin
            report($sformatf("word %0d arrived with none expected", words_seen));
         end else begin
            w = alerts_due.pop_front();
            if (st !== w.status)
               report($sformatf("word %0d status exp %0d got %0d", words_seen, w.status, st));
            if (room !== w.room)
               report($sformatf("word %0d room exp %0h got %0h", words_seen, w.room, room));
            if (avg !== w.average)
               report($sformatf("word %0d average exp %0d got %0d", words_seen,
                                w.average, avg));
         end
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_operation = sra_pkg::OP_LOAD;
   logic [DW-1:0]         req_sensor = '0;
   logic [DW-1:0]         req_room_id = '0;
   logic signed [DW-1:0]  req_sample_value = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [SW-1:0]         rsp_status;
   logic [DW-1:0]         rsp_room_out;
   logic signed [DW-1:0]  rsp_average;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [2:0]            paddr = '0;
   logic [31:0]           pwdata = '0;
   logic [31:0]           prdata;
   logic                  pready;

   alarm_scoreboard sb = new();
   int              cycle_count = 0;
   bit              no_idle = 1'b0;
   int              rsp_hold_cycles = 0;
   int              loads_issued = 0;
   logic [DW-1:0]   known_ids [$];

   sensor_running_average_alert #(
      .TABLE_ENTRIES (TABLE_SIZE),
      .HISTORY_LENGTH(RING_LEN)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_sensor      (req_sensor),
      .req_room_id     (req_room_id),
      .req_sample_value(req_sample_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_room_out    (rsp_room_out),
      .rsp_average     (rsp_average),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycle_count, sb.pending());
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send_word(logic op, logic [DW-1:0] sid, logic [DW-1:0] rid,
                            logic signed [DW-1:0] value);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_sensor       <= sid;
      req_room_id      <= rid;
      req_sample_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_input(op, sid, rid, value);
      if (op == sra_pkg::OP_LOAD) begin
         if (loads_issued < TABLE_SIZE) known_ids.push_back(sid);
         loads_issued++;
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic signed [DW-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {{(32 - DW){value[DW-1]}}, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.set_threshold(idx, value);
      @(posedge clock);
   endtask

   function automatic logic signed [DW-1:0] draw_reading();
      int t;
      case ($urandom_range(0, 7))
         0: t = int'($urandom_range(0, 16'hFFFF)) - 32768;
         1: t = $urandom_range(0, 1) ? 32767 : -32768;
         default: t = int'($urandom_range(0, 10000)) - 4000;
      endcase
      return DW'(t);
   endfunction

   task automatic send_random_word();
      int            r;
      logic [DW-1:0] sid;
      r = $urandom_range(0, 99);
      if (r < 12) begin
         if (known_ids.size() > 0 && $urandom_range(0, 9) < 3)
            sid = known_ids[$urandom_range(0, known_ids.size() - 1)];
         else
            sid = DW'($urandom());
         send_word(sra_pkg::OP_LOAD, sid, DW'($urandom()), draw_reading());
      end else if (r < 22) begin
         send_word(sra_pkg::OP_SAMPLE, DW'($urandom()), DW'($urandom()), draw_reading());
      end else begin
         sid = known_ids[$urandom_range(0, known_ids.size() - 1)];
         send_word(sra_pkg::OP_SAMPLE, sid, DW'($urandom()), draw_reading());
      end
   endtask

   task automatic set_phase(int p);
      logic signed [DW-1:0] hi;
      logic signed [DW-1:0] lo;
      case (p)
         0: begin hi = 16'sh7FFF; lo = 16'sh8000; end
         1: begin hi = 16'sh8000; lo = 16'sh7FFF; end
         2: begin hi = '0;        lo = '0;        end
         3: begin
            hi = DW'(int'($urandom_range(1000, 5000)));
            lo = DW'(int'($urandom_range(0, 5000)) - 3000);
         end
         default: begin hi = sra_pkg::MAX_TEMP_RESET; lo = sra_pkg::MIN_TEMP_RESET; end
      endcase
      csr_write(sra_pkg::REG_MAX_TEMP, hi);
      csr_write(sra_pkg::REG_MIN_TEMP, lo);
   endtask

   // response side
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         sb.check_result(rsp_status, rsp_room_out, rsp_average);
      end
   end

   // request side
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, extreme ids, duplicate, thresholds, ring wrap, truncation
      send_word(sra_pkg::OP_SAMPLE, 16'h1234, 16'hFFFF, 16'sh0000);
      send_word(sra_pkg::OP_LOAD,   16'h0000, 16'hFFFF, 16'sh7FFF);
      send_word(sra_pkg::OP_LOAD,   16'hFFFF, 16'h0000, 16'sh8000);
      send_word(sra_pkg::OP_LOAD,   16'h0000, 16'h1111, 16'sh0000);
      send_word(sra_pkg::OP_SAMPLE, 16'h0000, 16'h5555, 16'sd2500);
      send_word(sra_pkg::OP_SAMPLE, 16'h0000, 16'hAAAA, 16'sd2501);
      send_word(sra_pkg::OP_SAMPLE, 16'h0000, 16'h0000, -16'sd1);
      send_word(sra_pkg::OP_SAMPLE, 16'h0000, 16'hFFFF, 16'sh7FFF);
      send_word(sra_pkg::OP_SAMPLE, 16'h0000, 16'h0000, 16'sh7FFF);
      send_word(sra_pkg::OP_SAMPLE, 16'h0000, 16'h0000, 16'sh7FFF);
      repeat (5) send_word(sra_pkg::OP_SAMPLE, 16'h0000, 16'h0000, 16'sh8000);
      send_word(sra_pkg::OP_SAMPLE, 16'h0000, 16'h0000, 16'sd1000);
      send_word(sra_pkg::OP_SAMPLE, 16'h0000, 16'h0000, 16'sd999);
      send_word(sra_pkg::OP_SAMPLE, 16'hFFFF, 16'h0000, -16'sd7);
      send_word(sra_pkg::OP_SAMPLE, 16'hFFFF, 16'h0000, 16'sd2);
      send_word(sra_pkg::OP_SAMPLE, 16'h8000, 16'h0000, 16'sd2600);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         drain();
         set_phase(p);
         no_idle = (p == 1);
         if (p == 3) rsp_hold_cycles = LONG_HOLD;
         repeat (PHASE_WORDS) send_random_word();
      end
      no_idle = 1'b0;

      drain();
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
